>>> design/pzb_pkg.sv
`timescale 1ns / 1ps

package pzb_pkg;

    localparam int COORD_W = 16;
    localparam int FOCAL_W = 16;
    localparam int CX_W    = 10;
    localparam int CY_W    = 9;
    localparam int COL_W   = 11;
    localparam int ROW_W   = 10;
    localparam int DELTA_W = COORD_W + 1;
    localparam int MAG_W   = 32;
    localparam int DEN_W   = 24;
    localparam int POS_W   = 35;
    localparam int ENTRY_W = 3 * COORD_W + 1;

    localparam logic [2:0] REG_FOCAL = 3'd0;
    localparam logic [2:0] REG_CX    = 3'd1;
    localparam logic [2:0] REG_CY    = 3'd2;
    localparam logic [2:0] REG_CAMX  = 3'd3;
    localparam logic [2:0] REG_CAMY  = 3'd4;
    localparam logic [2:0] REG_CAMZ  = 3'd5;

    localparam logic MODE_SPLAT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

endpackage

>>> design/pzb_ram.sv
`timescale 1ns / 1ps

module pzb_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 921600
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/pinhole_project_zbuffer.sv
`timescale 1ns / 1ps

// Pinhole projection with a depth-tested point splat into a per-pixel store.
// A splat transaction forms the two focal products, then runs the restoring
// divider one quotient bit per cycle (column and row quotients run side by
// side on a shared denominator), then rounding, address forming, one memory
// read and the compare and write-back. A read transaction skips to address
// forming, the memory read and the compare; out-of-frame points, zero depth
// difference and reads outside the store finish early. One transaction is in
// flight at a time; its result sits in an output register so the next can be
// taken meanwhile. After reset a clearing pass writes every entry of the
// store, during which no transaction is accepted.
module pinhole_project_zbuffer #(
    parameter int MAX_COLS = 1280,
    parameter int MAX_ROWS = 720
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic signed [15:0] s_point_x,
    input  logic signed [15:0] s_point_y,
    input  logic signed [15:0] s_point_z,
    input  logic [10:0] s_read_col,
    input  logic [9:0]  s_read_row,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_pixel_col,
    output logic [9:0]  m_pixel_row,
    output logic        m_in_frame,
    output logic        m_depth_won,
    output logic signed [15:0] m_stored_x,
    output logic signed [15:0] m_stored_y,
    output logic signed [15:0] m_stored_z,
    output logic        m_stored_valid
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic signed [pzb_pkg::POS_W-1:0] POS_W_MAXC = pzb_pkg::POS_W'(MAX_COLS);
    localparam logic signed [pzb_pkg::POS_W-1:0] POS_W_MAXR = pzb_pkg::POS_W'(MAX_ROWS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_DIV, S_ROUND, S_ADDR, S_RD, S_CMP, S_FIN
    } state_t;

    state_t state_reg;

    logic [pzb_pkg::FOCAL_W-1:0] focal_reg;
    logic [pzb_pkg::CX_W-1:0]    cx_reg;
    logic [pzb_pkg::CY_W-1:0]    cy_reg;
    logic signed [pzb_pkg::COORD_W-1:0] camx_reg, camy_reg, camz_reg;

    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [4:0]        cnt_reg;

    logic mode_reg;
    logic signed [pzb_pkg::COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic signed [pzb_pkg::DELTA_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [pzb_pkg::COL_W-1:0] col_reg;
    logic [pzb_pkg::ROW_W-1:0] row_reg;
    logic inf_reg;

    logic [pzb_pkg::MAG_W-1:0] qc_reg, qr_reg;
    logic [pzb_pkg::DEN_W-1:0] rc_reg, rr_reg, den_reg;
    logic negc_reg, negr_reg;

    logic mem_we;
    logic [ADDR_W-1:0] mem_addr;
    logic [pzb_pkg::ENTRY_W-1:0] mem_wdata, mem_rdata;

    // configuration port
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_reg <= 16'd53209;
            cx_reg    <= 10'd640;
            cy_reg    <= 9'd360;
            camx_reg  <= '0;
            camy_reg  <= '0;
            camz_reg  <= 16'sd400;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                pzb_pkg::REG_FOCAL: focal_reg <= pwdata[15:0];
                pzb_pkg::REG_CX:    cx_reg    <= pwdata[9:0];
                pzb_pkg::REG_CY:    cy_reg    <= pwdata[8:0];
                pzb_pkg::REG_CAMX:  camx_reg  <= pwdata[15:0];
                pzb_pkg::REG_CAMY:  camy_reg  <= pwdata[15:0];
                pzb_pkg::REG_CAMZ:  camz_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            pzb_pkg::REG_FOCAL: prdata = {16'b0, focal_reg};
            pzb_pkg::REG_CX:    prdata = {22'b0, cx_reg};
            pzb_pkg::REG_CY:    prdata = {23'b0, cy_reg};
            pzb_pkg::REG_CAMX:  prdata = {{16{camx_reg[15]}}, camx_reg};
            pzb_pkg::REG_CAMY:  prdata = {{16{camy_reg[15]}}, camy_reg};
            pzb_pkg::REG_CAMZ:  prdata = {{16{camz_reg[15]}}, camz_reg};
            default:            prdata = '0;
        endcase
    end

    // datapath combinational helpers
    logic signed [33:0] prod_x, prod_y;
    logic [pzb_pkg::MAG_W-1:0] magc, magr;
    logic [pzb_pkg::DELTA_W-1:0] dz_abs;
    logic [pzb_pkg::DEN_W:0] shc, shr;
    logic bitc, bitr;
    logic [pzb_pkg::DEN_W:0] twoc, twor;
    logic [pzb_pkg::MAG_W:0] qcr, qrr;
    logic signed [pzb_pkg::POS_W-1:0] cpos, rpos;
    logic c_ok, r_ok;
    logic won;
    logic rd_in;

    assign prod_x = $signed({1'b0, focal_reg}) * $signed({{17{dx_reg[16]}}, dx_reg});
    assign prod_y = $signed({1'b0, focal_reg}) * $signed({{17{dy_reg[16]}}, dy_reg});
    assign magc   = prod_x[33] ? 32'(-prod_x) : prod_x[31:0];
    assign magr   = prod_y[33] ? 32'(-prod_y) : prod_y[31:0];
    assign dz_abs = dz_reg[16] ? 17'(-dz_reg) : dz_reg;

    assign shc  = {rc_reg, qc_reg[31]};
    assign shr  = {rr_reg, qr_reg[31]};
    assign bitc = shc >= {1'b0, den_reg};
    assign bitr = shr >= {1'b0, den_reg};

    assign twoc = {rc_reg, 1'b0};
    assign twor = {rr_reg, 1'b0};
    assign qcr  = {1'b0, qc_reg} + 33'((twoc > {1'b0, den_reg}) ||
                  (twoc == {1'b0, den_reg} && qc_reg[0]));
    assign qrr  = {1'b0, qr_reg} + 33'((twor > {1'b0, den_reg}) ||
                  (twor == {1'b0, den_reg} && qr_reg[0]));
    assign cpos = $signed({25'b0, cx_reg}) +
                  (negc_reg ? -$signed({2'b0, qcr}) : $signed({2'b0, qcr}));
    assign rpos = $signed({26'b0, cy_reg}) +
                  (negr_reg ? -$signed({2'b0, qrr}) : $signed({2'b0, qrr}));
    assign c_ok = !cpos[pzb_pkg::POS_W-1] && cpos < $signed({24'b0, cx_reg, 1'b0}) &&
                  cpos < POS_W_MAXC;
    assign r_ok = !rpos[pzb_pkg::POS_W-1] && rpos < $signed({25'b0, cy_reg, 1'b0}) &&
                  rpos < POS_W_MAXR;

    assign rd_in = (32'(s_read_col) < 32'(MAX_COLS)) && (32'(s_read_row) < 32'(MAX_ROWS));
    assign won   = !mem_rdata[48] || (pz_reg > $signed(mem_rdata[15:0]));

    assign s_ready   = (state_reg == S_IDLE);
    assign mem_addr  = (state_reg == S_CLEAR) ? clr_reg : addr_reg;
    assign mem_we    = (state_reg == S_CLEAR) ||
                       (state_reg == S_CMP && mode_reg == pzb_pkg::MODE_SPLAT && won);
    assign mem_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, px_reg, py_reg, pz_reg};

    pzb_ram #(.WIDTH(pzb_pkg::ENTRY_W), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    logic won_reg;
    logic [47:0] sto_reg;
    logic sv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            if (m_valid && m_ready && state_reg != S_FIN) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        mode_reg <= s_mode;
                        px_reg   <= s_point_x;
                        py_reg   <= s_point_y;
                        pz_reg   <= s_point_z;
                        dx_reg   <= 17'(s_point_x) - 17'(camx_reg);
                        dy_reg   <= 17'(s_point_y) - 17'(camy_reg);
                        dz_reg   <= 17'(s_point_z) - 17'(camz_reg);
                        won_reg  <= 1'b0;
                        sto_reg  <= '0;
                        sv_reg   <= 1'b0;
                        if (s_mode == pzb_pkg::MODE_READ) begin
                            col_reg   <= s_read_col;
                            row_reg   <= s_read_row;
                            inf_reg   <= 1'b0;
                            state_reg <= rd_in ? S_ADDR : S_FIN;
                        end else begin
                            col_reg   <= '0;
                            row_reg   <= '0;
                            inf_reg   <= 1'b0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    qc_reg   <= magc;
                    qr_reg   <= magr;
                    negc_reg <= !prod_x[33] ^ dz_reg[16] && (magc != '0);
                    negr_reg <= prod_y[33] ^ dz_reg[16];
                    rc_reg   <= '0;
                    rr_reg   <= '0;
                    den_reg  <= {dz_abs[15:0], 8'b0};
                    cnt_reg  <= '0;
                    state_reg <= (dz_reg == '0) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    rc_reg  <= bitc ? 24'(shc - {1'b0, den_reg}) : shc[23:0];
                    rr_reg  <= bitr ? 24'(shr - {1'b0, den_reg}) : shr[23:0];
                    qc_reg  <= {qc_reg[30:0], bitc};
                    qr_reg  <= {qr_reg[30:0], bitr};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (c_ok && r_ok) begin
                        col_reg   <= cpos[10:0];
                        row_reg   <= rpos[9:0];
                        inf_reg   <= 1'b1;
                        state_reg <= S_ADDR;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_ADDR: begin
                    addr_reg  <= ADDR_W'(32'(row_reg) * 32'(MAX_COLS) + 32'(col_reg));
                    state_reg <= S_RD;
                end
                S_RD: begin
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (mode_reg == pzb_pkg::MODE_SPLAT) begin
                        won_reg <= won;
                    end else if (mem_rdata[48]) begin
                        sto_reg <= mem_rdata[47:0];
                        sv_reg  <= 1'b1;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN: begin
                    if (!m_valid || m_ready) begin
                        m_valid        <= 1'b1;
                        m_pixel_col    <= col_reg;
                        m_pixel_row    <= row_reg;
                        m_in_frame     <= inf_reg;
                        m_depth_won    <= won_reg;
                        m_stored_x     <= sto_reg[47:32];
                        m_stored_y     <= sto_reg[31:16];
                        m_stored_z     <= sto_reg[15:0];
                        m_stored_valid <= sv_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
